// ===== src/scpr_pkg.sv =====
// scpr_pkg: shared types and constants of the soft edge circle pixel renderer
// no dependencies; imported by every module under src

package scpr_pkg;

  localparam int unsigned EdgeBits = 12;
  localparam int unsigned CfgIdxW  = 3;

  localparam int unsigned EdgeReset     = 16;
  localparam int unsigned InteriorReset = 65535;
  localparam int unsigned RowsReset     = 480;
  localparam int unsigned ColsReset     = 640;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX  = 3'd0,
    CfgCenterY  = 3'd1,
    CfgRadius   = 3'd2,
    CfgEdge     = 3'd3,
    CfgInterior = 3'd4,
    CfgExterior = 3'd5,
    CfgRows     = 3'd6,
    CfgCols     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RegionInterior = 2'd0,
    RegionBand     = 2'd1,
    RegionExterior = 2'd2
  } region_e;

endpackage

// ===== src/scpr_sqrt_cell.sv =====
// scpr_sqrt_cell: one bit step of the integer square root chain
// decides root bit STEP, passes remainder, partial root and region on
// depends on scpr_pkg

module scpr_sqrt_cell #(
  parameter int unsigned ROOT_W = 18,
  parameter int unsigned STEP   = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2*ROOT_W-1:0]     rem_i,
  input  logic [ROOT_W-1:0]       root_i,
  input  scpr_pkg::region_e       region_i,
  output logic                    valid_o,
  output logic [2*ROOT_W-1:0]     rem_o,
  output logic [ROOT_W-1:0]       root_o,
  output scpr_pkg::region_e       region_o
);
  import scpr_pkg::*;

  localparam int unsigned ValW = 2 * ROOT_W;

  logic [ValW:0]     rem_ext;
  logic [ValW:0]     trial;
  logic              take;
  logic              valid_q;
  logic [ValW-1:0]   rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;
  region_e           region_q;

  assign rem_ext = {1'b0, rem_i};
  // partial root holds only bits above STEP, so the add is an or
  assign trial = ((ValW+1)'(root_i) << (STEP + 1)) | ((ValW+1)'(1) << (2 * STEP));
  assign take  = rem_ext >= trial;

  always_comb begin
    rem_d  = rem_i;
    root_d = root_i;
    if (take) begin
      rem_d  = ValW'(rem_ext - trial);
      root_d = root_i | (ROOT_W'(1) << STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q    <= rem_d;
      root_q   <= root_d;
      region_q <= region_i;
    end
  end

  assign valid_o  = valid_q;
  assign rem_o    = rem_q;
  assign root_o   = root_q;
  assign region_o = region_q;

endmodule

// ===== src/scpr_div_cell.sv =====
// scpr_div_cell: one quotient bit of the restoring divider chain
// decides quotient bit STEP, passes remainder, quotient and region on
// depends on scpr_pkg

module scpr_div_cell #(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = 13,
  parameter int unsigned QUO_W = 16,
  parameter int unsigned STEP  = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NUM_W-1:0]   rem_i,
  input  logic [QUO_W-1:0]   quo_i,
  input  logic [DEN_W-1:0]   den_i,
  input  scpr_pkg::region_e  region_i,
  output logic               valid_o,
  output logic [NUM_W-1:0]   rem_o,
  output logic [QUO_W-1:0]   quo_o,
  output scpr_pkg::region_e  region_o
);
  import scpr_pkg::*;

  logic [NUM_W-1:0] den_sh;
  logic             take;
  logic             valid_q;
  logic [NUM_W-1:0] rem_d, rem_q;
  logic [QUO_W-1:0] quo_d, quo_q;
  region_e          region_q;

  assign den_sh = NUM_W'(den_i) << STEP;
  assign take   = rem_i >= den_sh;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    if (take) begin
      rem_d = rem_i - den_sh;
      quo_d = quo_i | (QUO_W'(1) << STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q    <= rem_d;
      quo_q    <= quo_d;
      region_q <= region_i;
    end
  end

  assign valid_o  = valid_q;
  assign rem_o    = rem_q;
  assign quo_o    = quo_q;
  assign region_o = region_q;

endmodule

// ===== src/soft_edge_circle_pixel_render_unit.sv =====
// soft_edge_circle_pixel_render_unit: top level of the soft edge circle renderer
// config registers, distance and blend stages, sqrt and divider cell chains
// depends on scpr_pkg, scpr_sqrt_cell, scpr_div_cell

// Renders one pixel of an antialiased circle per request: interior level inside
// radius minus half the edge width, exterior level beyond radius plus half the
// edge width, a linear blend rounded half up in between, and level 0 whenever
// the circle does not lie wholly inside the configured image. Throughput is one
// pixel per clock while the output is not stalled. A pixel passes stages a, b,
// c, the square root chain (one cell per root bit, COORD_BITS + FRAC_BITS + 2
// cells), stages e, f and g, the divider chain (one cell per level bit) and
// the output register. The output register holds a stalled result while new
// pixels keep entering until one reaches the end of the chain. Configuration
// is read live by the stages, so write it only while no pixel is in flight.

module soft_edge_circle_pixel_render_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4,
  parameter int unsigned LEVEL_BITS = 16,
  localparam int unsigned FixBits = COORD_BITS + FRAC_BITS,
  localparam int unsigned DimBits = COORD_BITS + 1,
  localparam int unsigned CfgW0   = (FixBits > DimBits) ? FixBits : DimBits,
  localparam int unsigned CfgW1   = (CfgW0 > LEVEL_BITS) ? CfgW0 : LEVEL_BITS,
  localparam int unsigned CfgW    = (CfgW1 > scpr_pkg::EdgeBits) ? CfgW1 : scpr_pkg::EdgeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         pixel_col_i,
  input  logic [COORD_BITS-1:0]         pixel_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [LEVEL_BITS-1:0]         level_o,
  output logic [1:0]                    region_o,
  output logic                          circle_fits_o
);
  import scpr_pkg::*;

  localparam int unsigned RootW = FixBits + 2;
  localparam int unsigned ValW  = 2 * RootW;
  localparam int unsigned MW    = (FixBits + 1 > EdgeBits) ? FixBits + 1 : EdgeBits;
  localparam int unsigned OutW  = MW + 1;
  localparam int unsigned TW    = MW + 3;
  localparam int unsigned CmpW  = (ValW > 2 * OutW) ? ValW : 2 * OutW;
  localparam int unsigned SpanW = EdgeBits + 1;
  localparam int unsigned NumW  = LEVEL_BITS + SpanW;

  // configuration registers
  logic [FixBits-1:0]    cx_q, cy_q, rad_q;
  logic [EdgeBits-1:0]   ew_q;
  logic [LEVEL_BITS-1:0] lin_q, lex_q;
  logic [DimBits-1:0]    rows_q, cols_q;

  logic pipe_en, out_free, last_valid;

  // stage a: distances and band bounds
  logic [FixBits-1:0] px, py;
  logic [MW:0]        rad2, ew_m;
  logic [FixBits-1:0] a_dx_d, a_dy_d;
  logic [OutW-1:0]    a_outer_d;
  logic [FixBits:0]   a_inner_d;
  logic               a_pos_d;
  logic               a_valid_q;
  logic [FixBits-1:0] a_dx_q, a_dy_q;
  logic [OutW-1:0]    a_outer_q;
  logic [FixBits:0]   a_inner_q;
  logic               a_pos_q;

  // stage b: squares
  logic                   b_valid_q;
  logic [2*FixBits-1:0]   b_dx2_q, b_dy2_q;
  logic [2*OutW-1:0]      b_outer2_q;
  logic [2*FixBits+1:0]   b_inner2_q;
  logic                   b_pos_q;

  // stage c: squared double distance and region
  logic [ValW-1:0] c_d4_d;
  region_e         c_region_d;
  logic            c_valid_q;
  logic [ValW-1:0] c_d4_q;
  region_e         c_region_q;

  // square root chain
  logic            sq_valid  [RootW+1];
  logic [ValW-1:0] sq_rem    [RootW+1];
  logic [RootW-1:0] sq_root  [RootW+1];
  region_e         sq_region [RootW+1];

  // stage e: blend weights
  logic [SpanW-1:0] span2;
  logic [TW-1:0]    off, tq;
  logic [SpanW-1:0] t_d;
  logic             e_valid_q;
  logic [SpanW-1:0] e_wi_q, e_we_q;
  region_e          e_region_q;

  // stage f: weighted levels
  logic            f_valid_q;
  logic [NumW-1:0] f_pi_q, f_pe_q;
  region_e         f_region_q;

  // stage g: rounded numerator
  logic            g_valid_q;
  logic [NumW-1:0] g_num_q;
  region_e         g_region_q;

  // divider chain
  logic                  dv_valid  [LEVEL_BITS+1];
  logic [NumW-1:0]       dv_rem    [LEVEL_BITS+1];
  logic [LEVEL_BITS-1:0] dv_quo    [LEVEL_BITS+1];
  region_e               dv_region [LEVEL_BITS+1];

  // output stage
  logic [FixBits:0]      cxr, cyr, colsf, rowsf;
  logic                  fits_d;
  logic [LEVEL_BITS-1:0] level_d;
  logic                  out_valid_q;
  logic [LEVEL_BITS-1:0] level_q;
  logic [1:0]            region_q;
  logic                  fits_q;

  assign last_valid = dv_valid[LEVEL_BITS];
  assign out_free   = !out_valid_q || out_ready_i;
  assign pipe_en    = out_free || !last_valid;
  assign in_ready_o = pipe_en;

  always_comb begin
    px        = FixBits'(pixel_col_i) << FRAC_BITS;
    py        = FixBits'(pixel_row_i) << FRAC_BITS;
    a_dx_d    = (px >= cx_q) ? px - cx_q : cx_q - px;
    a_dy_d    = (py >= cy_q) ? py - cy_q : cy_q - py;
    rad2      = (MW+1)'(rad_q) << 1;
    ew_m      = (MW+1)'(ew_q);
    a_outer_d = OutW'(rad2 + ew_m);
    a_pos_d   = rad2 > ew_m;
    a_inner_d = a_pos_d ? (FixBits+1)'(rad2 - ew_m) : '0;
  end

  always_comb begin
    c_d4_d = (ValW'(b_dx2_q) + ValW'(b_dy2_q)) << 2;
    if (CmpW'(c_d4_d) > CmpW'(b_outer2_q)) begin
      c_region_d = RegionExterior;
    end else if (b_pos_q && (c_d4_d < ValW'(b_inner2_q))) begin
      c_region_d = RegionInterior;
    end else begin
      c_region_d = RegionBand;
    end
  end

  assign sq_valid[0]  = c_valid_q;
  assign sq_rem[0]    = c_d4_q;
  assign sq_root[0]   = '0;
  assign sq_region[0] = c_region_q;

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    scpr_sqrt_cell #(
      .ROOT_W (RootW),
      .STEP   (RootW - 1 - i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (pipe_en),
      .valid_i  (sq_valid[i]),
      .rem_i    (sq_rem[i]),
      .root_i   (sq_root[i]),
      .region_i (sq_region[i]),
      .valid_o  (sq_valid[i+1]),
      .rem_o    (sq_rem[i+1]),
      .root_o   (sq_root[i+1]),
      .region_o (sq_region[i+1])
    );
  end

  // offset of the root against the inner bound, clamped to the band
  always_comb begin
    span2 = SpanW'(ew_q) << 1;
    off   = (TW'(rad_q) << 1) - TW'(ew_q);
    tq    = TW'(sq_root[RootW]) - off;
    if (tq[TW-1]) begin
      t_d = '0;
    end else if (tq > TW'(span2)) begin
      t_d = span2;
    end else begin
      t_d = SpanW'(tq);
    end
  end

  assign dv_valid[0]  = g_valid_q;
  assign dv_rem[0]    = g_num_q;
  assign dv_quo[0]    = '0;
  assign dv_region[0] = g_region_q;

  for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_div
    scpr_div_cell #(
      .NUM_W (NumW),
      .DEN_W (SpanW),
      .QUO_W (LEVEL_BITS),
      .STEP  (LEVEL_BITS - 1 - k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (pipe_en),
      .valid_i  (dv_valid[k]),
      .rem_i    (dv_rem[k]),
      .quo_i    (dv_quo[k]),
      .den_i    (span2),
      .region_i (dv_region[k]),
      .valid_o  (dv_valid[k+1]),
      .rem_o    (dv_rem[k+1]),
      .quo_o    (dv_quo[k+1]),
      .region_o (dv_region[k+1])
    );
  end

  always_comb begin
    cxr    = (FixBits+1)'(cx_q) + (FixBits+1)'(rad_q);
    cyr    = (FixBits+1)'(cy_q) + (FixBits+1)'(rad_q);
    colsf  = (FixBits+1)'(cols_q) << FRAC_BITS;
    rowsf  = (FixBits+1)'(rows_q) << FRAC_BITS;
    fits_d = (cx_q >= rad_q) && (cy_q >= rad_q) && (cxr <= colsf) && (cyr <= rowsf);
    case (dv_region[LEVEL_BITS])
      RegionInterior: level_d = lin_q;
      RegionExterior: level_d = lex_q;
      RegionBand:     level_d = (ew_q == '0) ? lin_q : dv_quo[LEVEL_BITS];
      default:        level_d = '0;
    endcase
    if (!fits_d) begin
      level_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      rad_q       <= '0;
      ew_q        <= EdgeBits'(EdgeReset);
      lin_q       <= LEVEL_BITS'(InteriorReset);
      lex_q       <= '0;
      rows_q      <= DimBits'(RowsReset);
      cols_q      <= DimBits'(ColsReset);
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      g_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CfgCenterX:  cx_q   <= FixBits'(cfg_data_i);
          CfgCenterY:  cy_q   <= FixBits'(cfg_data_i);
          CfgRadius:   rad_q  <= FixBits'(cfg_data_i);
          CfgEdge:     ew_q   <= EdgeBits'(cfg_data_i);
          CfgInterior: lin_q  <= LEVEL_BITS'(cfg_data_i);
          CfgExterior: lex_q  <= LEVEL_BITS'(cfg_data_i);
          CfgRows:     rows_q <= DimBits'(cfg_data_i);
          CfgCols:     cols_q <= DimBits'(cfg_data_i);
          default: ;
        endcase
      end
      if (pipe_en) begin
        a_valid_q <= in_valid_i;
        b_valid_q <= a_valid_q;
        c_valid_q <= b_valid_q;
        e_valid_q <= sq_valid[RootW];
        f_valid_q <= e_valid_q;
        g_valid_q <= f_valid_q;
      end
      if (out_free) begin
        out_valid_q <= last_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_dx_q     <= a_dx_d;
      a_dy_q     <= a_dy_d;
      a_outer_q  <= a_outer_d;
      a_inner_q  <= a_inner_d;
      a_pos_q    <= a_pos_d;
      b_dx2_q    <= (2*FixBits)'(a_dx_q * a_dx_q);
      b_dy2_q    <= (2*FixBits)'(a_dy_q * a_dy_q);
      b_outer2_q <= (2*OutW)'(a_outer_q * a_outer_q);
      b_inner2_q <= (2*FixBits+2)'(a_inner_q * a_inner_q);
      b_pos_q    <= a_pos_q;
      c_d4_q     <= c_d4_d;
      c_region_q <= c_region_d;
      e_wi_q     <= span2 - t_d;
      e_we_q     <= t_d;
      e_region_q <= sq_region[RootW];
      f_pi_q     <= NumW'(lin_q * e_wi_q);
      f_pe_q     <= NumW'(lex_q * e_we_q);
      f_region_q <= e_region_q;
      g_num_q    <= f_pi_q + f_pe_q + NumW'(ew_q);
      g_region_q <= f_region_q;
    end
    if (out_free) begin
      level_q  <= level_d;
      region_q <= dv_region[LEVEL_BITS];
      fits_q   <= fits_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_o       = level_q;
  assign region_o      = region_q;
  assign circle_fits_o = fits_q;

  a_no_fit_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !circle_fits_o |-> level_o == '0)
    else $error("level not zero for a circle that does not fit");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

endmodule

// ===== test/scpr_render_checker.sv =====
// scpr_render_checker: watches the config port and both pixel channels of the circle renderer
// predicts each rendered pixel from its own copy of the registers and compares the results
// depends on scpr_pkg

module scpr_render_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4,
  parameter int unsigned LEVEL_BITS = 16,
  parameter int unsigned CFG_W      = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [COORD_BITS-1:0]  pixel_col_i,
  input  logic [COORD_BITS-1:0]  pixel_row_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [LEVEL_BITS-1:0]  level_i,
  input  logic [1:0]             region_i,
  input  logic                   circle_fits_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scpr_pkg::*;

  localparam int unsigned FixBits = COORD_BITS + FRAC_BITS;
  localparam int unsigned DimBits = COORD_BITS + 1;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    region_e               region;
    logic                  fits;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  logic [63:0] ctr_col, ctr_row, rad, band, lvl_in, lvl_out, img_rows, img_cols;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic pixel_result_t render_pixel(logic [COORD_BITS-1:0] col,
                                                 logic [COORD_BITS-1:0] row);
    logic [63:0] px, py, dx, dy, dist4, outer, inner, root, t, two_s, lvl;
    logic inner_pos;
    logic fits;
    pixel_result_t res;
    px = 64'(col) << FRAC_BITS;
    py = 64'(row) << FRAC_BITS;
    dx = (px >= ctr_col) ? px - ctr_col : ctr_col - px;
    dy = (py >= ctr_row) ? py - ctr_row : ctr_row - py;
    dist4 = 4 * (dx * dx + dy * dy);
    outer = 2 * rad + band;
    inner_pos = (2 * rad > band);
    inner = inner_pos ? 2 * rad - band : 64'd0;
    if (dist4 > outer * outer) begin
      res.region = RegionExterior;
      lvl = lvl_out;
    end else if (inner_pos && dist4 < inner * inner) begin
      res.region = RegionInterior;
      lvl = lvl_in;
    end else begin
      res.region = RegionBand;
      if (band == 0) begin
        lvl = lvl_in;
      end else begin
        root = int_sqrt(dist4);
        two_s = 2 * band;
        if (inner_pos) t = (root > inner) ? root - inner : 64'd0;
        else t = root + (band - 2 * rad);
        if (t > two_s) t = two_s;
        lvl = (lvl_in * (two_s - t) + lvl_out * t + band) / two_s;
      end
    end
    fits = !(ctr_col < rad || ctr_row < rad ||
             ctr_col + rad > (img_cols << FRAC_BITS) ||
             ctr_row + rad > (img_rows << FRAC_BITS));
    if (!fits) lvl = '0;
    res.level = lvl[LEVEL_BITS-1:0];
    res.fits = fits;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t exp_px;
    if (!rst_ni) begin
      ctr_col = '0;
      ctr_row = '0;
      rad = '0;
      band = 64'(EdgeReset);
      lvl_in = 64'(InteriorReset);
      lvl_out = '0;
      img_rows = 64'(RowsReset);
      img_cols = 64'(ColsReset);
      expected_pixels.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgCenterX:  ctr_col = 64'(cfg_data_i[FixBits-1:0]);
          CfgCenterY:  ctr_row = 64'(cfg_data_i[FixBits-1:0]);
          CfgRadius:   rad = 64'(cfg_data_i[FixBits-1:0]);
          CfgEdge:     band = 64'(cfg_data_i[EdgeBits-1:0]);
          CfgInterior: lvl_in = 64'(cfg_data_i[LEVEL_BITS-1:0]);
          CfgExterior: lvl_out = 64'(cfg_data_i[LEVEL_BITS-1:0]);
          CfgRows:     img_rows = 64'(cfg_data_i[DimBits-1:0]);
          CfgCols:     img_cols = 64'(cfg_data_i[DimBits-1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no pending request: level %0d region %0d fits %0d",
                 level_i, region_i, circle_fits_i);
          fail_count_o++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (level_i !== exp_px.level) begin
            $error("level mismatch: expected %0d, got %0d", exp_px.level, level_i);
            fail_count_o++;
          end
          if (region_i !== exp_px.region) begin
            $error("region mismatch: expected %0d, got %0d", exp_px.region, region_i);
            fail_count_o++;
          end
          if (circle_fits_i !== exp_px.fits) begin
            $error("circle_fits mismatch: expected %0d, got %0d", exp_px.fits, circle_fits_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_pixels.insert(expected_pixels.size(), render_pixel(pixel_col_i, pixel_row_i));
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== test/soft_edge_circle_pixel_render_unit_tb.sv =====
// soft_edge_circle_pixel_render_unit_tb: drives circle settings and pixel requests into the renderer
// with random gaps and output stalls; verdict from the failure count of scpr_render_checker
// depends on scpr_pkg, soft_edge_circle_pixel_render_unit and scpr_render_checker

module soft_edge_circle_pixel_render_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scpr_pkg::*;

  localparam int unsigned PixelTarget = 1300;
  localparam int unsigned DrainCycles = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_reg_e    cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [11:0] pixel_col_i;
  logic [11:0] pixel_row_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] level_o;
  logic [1:0]  region_o;
  logic        circle_fits_o;

  int          failures;
  int          in_flight;
  int unsigned random_sent;
  bit          no_gaps;
  logic [15:0] cur_cx, cur_cy, cur_r;
  logic [11:0] cur_s;

  soft_edge_circle_pixel_render_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .level_o       (level_o),
    .region_o      (region_o),
    .circle_fits_o (circle_fits_o)
  );

  scpr_render_checker u_render_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .level_i       (level_o),
    .region_i      (region_o),
    .circle_fits_i (circle_fits_o),
    .fail_count_o  (failures),
    .pending_o     (in_flight)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_circle(logic [15:0] cx, logic [15:0] cy, logic [15:0] r, logic [15:0] s,
                            logic [15:0] lvl_in, logic [15:0] lvl_out,
                            logic [15:0] rows, logic [15:0] cols);
    write_reg(CfgCenterX, cx);
    write_reg(CfgCenterY, cy);
    write_reg(CfgRadius, r);
    write_reg(CfgEdge, s);
    write_reg(CfgInterior, lvl_in);
    write_reg(CfgExterior, lvl_out);
    write_reg(CfgRows, rows);
    write_reg(CfgCols, cols);
    cur_cx = cx;
    cur_cy = cy;
    cur_r = r;
    cur_s = s[11:0];
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 16) return 16'h1fff;
    if (r < 22) return 16'd4096;
    if (r < 26) return 16'd1;
    if (r < 32) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(16, 4096));
  endfunction

  function automatic logic [15:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 30) return 16'hffff;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_center(logic [15:0] r, logic [15:0] dim);
    int unsigned lim, hi, sel;
    lim = int'(dim[12:0]) * 16;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 16'd0;
    if (sel < 10) return 16'hffff;
    if (sel < 80 && 2 * int'(r) <= lim) begin
      hi = lim - r;
      if (hi > 65535) hi = 65535;
      return 16'($urandom_range(r, hi));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_circle();
    logic [15:0] rows, cols, r, s;
    int unsigned sel;
    rows = pick_dim();
    cols = pick_dim();
    sel = $urandom_range(0, 99);
    if (sel < 10) r = 16'd0;
    else if (sel < 15) r = 16'hffff;
    else if (sel < 60) r = 16'($urandom_range(16, 800));
    else r = 16'($urandom_range(0, 4000));
    sel = $urandom_range(0, 99);
    if (sel < 10) s = 16'd0;
    else if (sel < 18) s = 16'h0fff;
    else if (sel < 22) s = 16'd1;
    else if (sel < 28) s = 16'($urandom_range(0, 65535));
    else s = 16'($urandom_range(2, 160));
    set_circle(pick_center(r, cols), pick_center(r, rows), r, s,
               pick_level(), pick_level(), rows, cols);
  endtask

  function automatic logic [11:0] near_coord(logic [15:0] ctr, int span);
    int c;
    c = int'(ctr >> 4) + int'($urandom_range(0, 2 * span)) - span;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return 12'(c);
  endfunction

  task automatic send_random_pixel();
    int span;
    span = int'((cur_r + 17'(cur_s)) >> 4) + 3;
    if (span > 4095) span = 4095;
    if ($urandom_range(0, 99) < 65) begin
      send_pixel(near_coord(cur_cx, span), near_coord(cur_cy, span));
    end else begin
      send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
      repeat (n - 1) @(negedge clk_i);
      n = stall_len();
      if (n > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    int unsigned burst;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgCenterX;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    no_gaps = 1'b0;
    random_sent = 0;
    cur_cx = '0;
    cur_cy = '0;
    cur_r = '0;
    cur_s = 12'(EdgeReset);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero radius at the origin
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // ordinary circle, pixels across the soft edge and outside the image
    set_circle(16'd1608, 16'd1284, 16'd480, 16'd32, 16'd60000, 16'd1000, 16'd480, 16'd640);
    send_pixel(12'd100, 12'd80);
    send_pixel(12'd69, 12'd80);
    send_pixel(12'd70, 12'd80);
    send_pixel(12'd71, 12'd80);
    send_pixel(12'd72, 12'd80);
    send_pixel(12'd130, 12'd80);
    send_pixel(12'd131, 12'd80);
    send_pixel(12'd132, 12'd80);
    send_pixel(12'd700, 12'd80);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // zero edge width, pixel exactly on the radius
    set_circle(16'd800, 16'd800, 16'd160, 16'd0, 16'd12345, 16'd54321, 16'd480, 16'd640);
    send_pixel(12'd60, 12'd50);
    send_pixel(12'd59, 12'd50);
    send_pixel(12'd61, 12'd50);
    send_pixel(12'd50, 12'd60);
    drain();

    // band wider than the circle, circle not fitting
    set_circle(16'd800, 16'd800, 16'd1600, 16'hffff, 16'd40000, 16'd20000, 16'd480, 16'd640);
    send_pixel(12'd50, 12'd50);
    send_pixel(12'd200, 12'd50);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // largest settings, oversize image
    set_circle(16'hffff, 16'hffff, 16'hffff, 16'h0fff, 16'hffff, 16'd0, 16'h1fff, 16'h1fff);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    drain();

    // zero image size with a zero circle
    set_circle(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    drain();

    while (random_sent < PixelTarget) begin
      random_circle();
      no_gaps = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(30, 150);
      repeat (burst) begin
        send_random_pixel();
        random_sent++;
      end
      drain();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (failures == 0 && in_flight == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
